>>> rtl/serial_packet_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// serial packet deframer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPDU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spdu assertion failed");

// next-cycle implication, disabled during reset
`define SPDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spdu assertion failed");

`endif

>>> rtl/spdu_pkg.sv
// ----------------------------------------------------------------------------
// spdu_pkg
// types and constants shared by the serial packet deframer modules
// ----------------------------------------------------------------------------
`default_nettype none

package spdu_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 32;

    localparam logic [7:0] TRAILER_BYTE       = 8'hFF;
    localparam logic [7:0] START_BYTE_RESET   = 8'd170;
    localparam logic [5:0] LENGTH_LIMIT_RESET = 6'd32;

    // register indexes, taken from paddr[2]
    localparam logic REG_START_BYTE   = 1'b0;
    localparam logic REG_LENGTH_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        S_HUNT,
        S_ID,
        S_LEN,
        S_DATA,
        S_TRAILER,
        S_READ,
        S_SEND
    } t_state;

    typedef struct packed {
        logic load_id;
        logic load_len;
        logic store_byte;
        logic clear_emit;
        logic read_mem;
        logic advance_emit;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic len_ok;
        logic len_zero;
        logic fill_done;
        logic trailer_ok;
        logic frame_empty;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/spdu_controller.sv
// ----------------------------------------------------------------------------
// spdu_controller
// frame phase state machine, issues commands to the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module spdu_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_m_tready,
    input  wire spdu_pkg::t_status i_status,
    output spdu_pkg::t_cmd        o_cmd,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid
);
    import spdu_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_in_acc;

    assign w_in_acc = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_HUNT: begin
                if (w_in_acc && i_status.is_start) n_state = S_ID;
            end
            S_ID: begin
                if (w_in_acc) n_state = S_LEN;
            end
            S_LEN: begin
                if (w_in_acc) begin
                    if (!i_status.len_ok) n_state = S_HUNT;
                    else if (i_status.len_zero) n_state = S_TRAILER;
                    else n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (w_in_acc && i_status.fill_done) n_state = S_TRAILER;
            end
            S_TRAILER: begin
                if (w_in_acc) begin
                    if (!i_status.trailer_ok) n_state = S_HUNT;
                    else if (i_status.frame_empty) n_state = S_SEND;
                    else n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_m_tready) n_state = i_status.emit_last ? S_HUNT : S_READ;
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state) inside
            S_HUNT, S_ID, S_LEN, S_DATA, S_TRAILER: begin
                o_s_tready = 1'b1;
            end
            S_SEND: begin
                o_m_tvalid = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.load_id      = (r_state == S_ID) && w_in_acc;
        o_cmd.load_len     = (r_state == S_LEN) && w_in_acc && i_status.len_ok;
        o_cmd.store_byte   = (r_state == S_DATA) && w_in_acc;
        o_cmd.clear_emit   = (r_state == S_TRAILER) && w_in_acc;
        o_cmd.read_mem     = (r_state == S_READ);
        o_cmd.advance_emit = (r_state == S_SEND) && i_m_tready && !i_status.emit_last;
    end

endmodule

`default_nettype wire

>>> rtl/spdu_datapath.sv
// ----------------------------------------------------------------------------
// spdu_datapath
// config registers, frame header registers, payload store and result fields
// ----------------------------------------------------------------------------
`default_nettype none

module spdu_datapath #(
    parameter int MAX_PAYLOAD = spdu_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_byte,
    input  wire spdu_pkg::t_cmd    i_cmd,
    output spdu_pkg::t_status      o_status,
    input  wire logic              i_cfg_wr,
    input  wire logic              i_cfg_idx,
    input  wire logic [31:0]       i_cfg_wdata,
    output logic [31:0]            o_cfg_rdata,
    output logic [31:0]            o_tdata,
    output logic [0:0]             o_tuser
);
    import spdu_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] r_start_byte;
    logic [5:0] r_length_limit;
    logic [7:0] r_frame_id;
    logic [5:0] r_frame_length;
    logic [5:0] r_fill_index;
    logic [5:0] r_emit_idx;
    logic [7:0] r_rd_data;
    logic [7:0] r_mem [MAX_PAYLOAD];

    logic [5:0] w_fill_next;
    logic [5:0] w_emit_next;
    logic       w_has_payload;

    assign w_fill_next   = r_fill_index + 6'd1;
    assign w_emit_next   = r_emit_idx + 6'd1;
    assign w_has_payload = (r_frame_length != 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= START_BYTE_RESET;
            r_length_limit <= LENGTH_LIMIT_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                REG_START_BYTE:   r_start_byte   <= i_cfg_wdata[7:0];
                REG_LENGTH_LIMIT: r_length_limit <= i_cfg_wdata[5:0];
                default:          r_start_byte   <= r_start_byte;
            endcase
        end
    end

    always_comb begin
        o_cfg_rdata = '0;
        case (i_cfg_idx)
            REG_START_BYTE:   o_cfg_rdata = {24'd0, r_start_byte};
            REG_LENGTH_LIMIT: o_cfg_rdata = {26'd0, r_length_limit};
            default:          o_cfg_rdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_id     <= '0;
            r_frame_length <= '0;
            r_fill_index   <= '0;
            r_emit_idx     <= '0;
        end else begin
            if (i_cmd.load_id) r_frame_id <= i_byte;
            if (i_cmd.load_len) begin
                r_frame_length <= i_byte[5:0];
                r_fill_index   <= '0;
            end else if (i_cmd.store_byte) begin
                r_fill_index <= w_fill_next;
            end
            if (i_cmd.clear_emit) r_emit_idx <= '0;
            else if (i_cmd.advance_emit) r_emit_idx <= w_emit_next;
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && ({1'b0, r_fill_index} < 7'(MAX_PAYLOAD))) begin
            r_mem[r_fill_index[AW-1:0]] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_mem) r_rd_data <= r_mem[r_emit_idx[AW-1:0]];
    end

    always_comb begin
        o_status             = '0;
        o_status.is_start    = (i_byte == r_start_byte);
        o_status.len_ok      = (i_byte <= {2'b00, r_length_limit}) &&
                               (i_byte <= 8'(MAX_PAYLOAD));
        o_status.len_zero    = (i_byte == 8'd0);
        o_status.fill_done   = (w_fill_next >= r_frame_length);
        o_status.trailer_ok  = (i_byte == TRAILER_BYTE);
        o_status.frame_empty = !w_has_payload;
        o_status.emit_last   = !w_has_payload || (w_emit_next == r_frame_length);
    end

    // tdata: msg_id, payload_length, byte_index, payload_byte, zero pad
    assign o_tdata = {5'd0,
                      w_has_payload ? r_rd_data : 8'd0,
                      r_emit_idx[4:0],
                      r_frame_length,
                      r_frame_id};
    assign o_tuser = w_has_payload;

endmodule

`default_nettype wire

>>> rtl/serial_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer_unit
// pulls length-prefixed frames out of a received serial byte stream
// ----------------------------------------------------------------------------
// input stream carries one received byte per transaction; a frame is the
// start byte, a message id, a length byte, that many payload bytes and a
// 0xFF trailer. header, payload and trailer bytes are accepted back to back.
// after a good trailer the frame comes out on the output stream as one
// transaction per payload byte (tlast on the final one), or as a single
// transaction with tuser low for an empty frame. each payload result is
// produced by a payload store read and then held on the output (an empty
// frame goes straight to the output hold); the next byte is read only once
// the current result is taken with tready high.
// the input stream is held off (tready low) until the run is fully taken;
// when the receiver stalls, the current result is held stable.
// oversize lengths and bad trailers drop the frame with no output.
// the apb port sets the start byte (0x0) and length limit (0x4), pready is
// always high. reset returns to hunting with the default registers; no
// payload store clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_packet_deframer_unit #(
    parameter int MAX_PAYLOAD = spdu_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // byte_in
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // msg_id, payload_length, byte_index, payload_byte
    output logic [0:0]       o_m_tuser,   // has_payload
    output logic             o_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import spdu_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign o_m_tlast = w_status.emit_last;

    spdu_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    spdu_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_wr    (w_cfg_wr),
        .i_cfg_idx   (paddr[2]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .o_tdata     (o_m_tdata),
        .o_tuser     (o_m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/spdu_checker.sv
// ----------------------------------------------------------------------------
// spdu_checker
// port-level assertions for the serial packet deframer, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_packet_deframer_unit_assert.svh"

module spdu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic [0:0]  o_m_tuser,
    input wire logic        o_m_tlast
);

    // stalled result holds
    `SPDU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // input is held off while a run is being delivered
    `SPDU_ASSERT_NOW(a_no_in_during_out, i_clk, i_rst_n, o_m_tvalid, !o_s_tready)

    // an empty frame is a single result
    `SPDU_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tlast && (o_m_tdata[13:8] == 6'd0))

    // payload index stays below the frame length, for lengths up to 32
    `SPDU_ASSERT_NOW(a_index_in_range, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], ({1'b0, o_m_tdata[18:14]} < o_m_tdata[13:8]) || (o_m_tdata[13:8] > 6'd32))

endmodule

bind serial_packet_deframer_unit spdu_checker u_spdu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
